// ===== rtl/core/bcntbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn texture block decoder package
// Shared types, constants and arithmetic helpers for the decoder core.
// ----------------------------------------------------------------------------
package bcntbd_pkg;

   localparam int BLOCK_W     = 64;
   localparam int TEXEL_W     = 32;
   localparam int ROW_TEXELS  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ROW_LAST = 2'd3;

   // Reciprocals for exact floor division of the palette numerators.
   localparam int RECIP3  = 683;
   localparam int SHIFT3  = 11;
   localparam int RECIP5  = 1639;
   localparam int SHIFT5  = 13;
   localparam int RECIP7  = 2341;
   localparam int SHIFT7  = 14;

   typedef enum logic [1:0] {
      MODE_BC1  = 2'd0,
      MODE_BC3  = 2'd1,
      MODE_BC4  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [1:0][2:0][7:0]   ends;
      logic                   c_gt;
      logic [7:0]             a0;
      logic [7:0]             a1;
      logic                   a_gt;
      logic [15:0][1:0]       cidx;
      logic [15:0][2:0]       aidx;
   } stage_type;

   typedef struct packed {
      mode_type               mode;
      logic [3:0][31:0]       cpal;
      logic [7:0][7:0]        apal;
      logic [15:0][1:0]       cidx;
      logic [15:0][2:0]       aidx;
   } blk_type;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0] t;
      logic [2:0] q;
      t = 8'({3'b000, v} * 8'd7);
      q = 3'd0;
      for (int k = 1; k <= 7; k++) begin
         q = q + 3'(t >= 8'(31 * k));
      end
      return {v, 3'b000} + {5'b00000, q};
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] q;
      q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + {6'b000000, q};
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [19:0] p;
      p = 20'(n) * 20'(RECIP3);
      return p[SHIFT3+7:SHIFT3];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] n);
      logic [21:0] p;
      p = 22'(n) * 22'(RECIP5);
      return p[SHIFT5+7:SHIFT5];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] n);
      logic [22:0] p;
      p = 23'(n) * 23'(RECIP7);
      return p[SHIFT7+7:SHIFT7];
   endfunction

endpackage

// ===== rtl/core/bcntbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn decoder front end
// Accepts compressed blocks, classifies the mode and builds both palettes.
// ----------------------------------------------------------------------------
module bcntbd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [127:0]          req_tdata,   // color_block, alpha_block
   input  logic [1:0]            req_tuser,   // op
   output logic                  blk_vld,
   input  logic                  blk_rdy,
   output bcntbd_pkg::blk_type   blk_data
);

   logic                  stg_vld_ff;
   logic                  stg_vld_in;
   bcntbd_pkg::stage_type stg_ff;
   bcntbd_pkg::stage_type stg_in;
   logic                  accept;
   logic [63:0]           cblk;
   logic [63:0]           ablk;

   assign cblk       = req_tdata[63:0];
   assign ablk       = req_tdata[127:64];
   assign req_tready = !stg_vld_ff || blk_rdy;
   assign accept     = req_tvalid && req_tready;
   assign stg_vld_in = accept ? 1'b1 : (blk_rdy ? 1'b0 : stg_vld_ff);

   always_comb begin
      stg_in.mode = bcntbd_pkg::mode_type'(req_tuser);
      for (int j = 0; j < 2; j++) begin
         stg_in.ends[j][0] = bcntbd_pkg::expand5(cblk[16*j+11 +: 5]);
         stg_in.ends[j][1] = bcntbd_pkg::expand6(cblk[16*j+5 +: 6]);
         stg_in.ends[j][2] = bcntbd_pkg::expand5(cblk[16*j +: 5]);
      end
      stg_in.c_gt = cblk[15:0] > cblk[31:16];
      stg_in.a0   = ablk[7:0];
      stg_in.a1   = ablk[15:8];
      stg_in.a_gt = ablk[7:0] > ablk[15:8];
      stg_in.cidx = cblk[63:32];
      stg_in.aidx = ablk[63:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
   end

   always_comb begin
      logic [7:0] e0;
      logic [7:0] e1;
      logic [9:0] third_a;
      logic [9:0] third_b;
      logic [8:0] pair;
      logic [10:0] n7;
      logic [10:0] n5;
      blk_data.mode = stg_ff.mode;
      blk_data.cidx = stg_ff.cidx;
      blk_data.aidx = stg_ff.aidx;
      blk_data.cpal[0][31:24] = 8'hff;
      blk_data.cpal[1][31:24] = 8'hff;
      blk_data.cpal[2][31:24] = 8'hff;
      blk_data.cpal[3][31:24] = stg_ff.c_gt ? 8'hff : 8'h00;
      for (int k = 0; k < 3; k++) begin
         e0      = stg_ff.ends[0][k];
         e1      = stg_ff.ends[1][k];
         third_a = {1'b0, e0, 1'b0} + {2'b00, e1};
         third_b = {2'b00, e0} + {1'b0, e1, 1'b0};
         pair    = {1'b0, e0} + {1'b0, e1};
         blk_data.cpal[0][8*k +: 8] = e0;
         blk_data.cpal[1][8*k +: 8] = e1;
         blk_data.cpal[2][8*k +: 8] = stg_ff.c_gt ? bcntbd_pkg::div3(third_a) : pair[8:1];
         blk_data.cpal[3][8*k +: 8] = stg_ff.c_gt ? bcntbd_pkg::div3(third_b) : 8'h00;
      end
      blk_data.apal[0] = stg_ff.a0;
      blk_data.apal[1] = stg_ff.a1;
      for (int i = 1; i <= 6; i++) begin
         n7 = 11'(stg_ff.a0) * 11'(7 - i) + 11'(stg_ff.a1) * 11'(i);
         n5 = 11'(stg_ff.a0) * 11'(5 - i) + 11'(stg_ff.a1) * 11'(i);
         if (stg_ff.a_gt) begin
            blk_data.apal[3'(i + 1)] = bcntbd_pkg::div7(n7);
         end else if (i <= 4) begin
            blk_data.apal[3'(i + 1)] = bcntbd_pkg::div5(n5);
         end else if (i == 5) begin
            blk_data.apal[3'(i + 1)] = 8'h00;
         end else begin
            blk_data.apal[3'(i + 1)] = 8'hff;
         end
      end
   end

   assign blk_vld = stg_vld_ff;

endmodule

// ===== rtl/core/bcntbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn decoder block queue
// Small first-in first-out buffer of decoded palettes between front and back.
// ----------------------------------------------------------------------------
module bcntbd_queue #(
   parameter int DEPTH = bcntbd_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_rdy,
   input  bcntbd_pkg::blk_type   in_data,
   output logic                  out_vld,
   input  logic                  out_rdy,
   output bcntbd_pkg::blk_type   out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcntbd_pkg::blk_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                push;
   logic                pop;

   assign in_rdy   = count_ff != CNT_W'(DEPTH);
   assign out_vld  = count_ff != '0;
   assign out_data = slot_ff[rd_ptr_ff];
   assign push     = in_vld && in_rdy;
   assign pop      = out_vld && out_rdy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/core/bcntbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn decoder back end
// Looks up one row of texels per cycle into the result register while it is free.
// ----------------------------------------------------------------------------
module bcntbd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  blk_vld,
   output logic                  blk_rdy,
   input  bcntbd_pkg::blk_type   blk_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // texel_0, texel_1, texel_2, texel_3
   output logic [1:0]            rsp_tuser,   // row_index
   output logic                  rsp_tlast    // last_row
);

   bcntbd_pkg::blk_type cur_ff;
   logic                cur_vld_ff;
   logic                cur_vld_in;
   logic [1:0]          row_ff;
   logic [1:0]          row_in;
   logic                rsp_vld_ff;
   logic                rsp_vld_in;
   logic [3:0][31:0]    rsp_data_ff;
   logic [3:0][31:0]    rsp_data_in;
   logic [1:0]          rsp_row_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                load_row;
   logic                done;
   logic                pop;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign load_row   = cur_vld_ff && out_free;
   assign done       = load_row && (row_ff == bcntbd_pkg::ROW_LAST);
   assign pop        = blk_vld && (!cur_vld_ff || done);
   assign blk_rdy    = !cur_vld_ff || done;
   assign cur_vld_in = pop ? 1'b1 : (done ? 1'b0 : cur_vld_ff);
   assign row_in     = pop ? 2'd0 : (load_row ? row_ff + 2'd1 : row_ff);
   assign rsp_vld_in = load_row ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_comb begin
      logic [3:0] t;
      logic [1:0] ci;
      logic [2:0] ai;
      logic [7:0] a;
      for (int c = 0; c < bcntbd_pkg::ROW_TEXELS; c++) begin
         t  = {row_ff, 2'(c)};
         ci = cur_ff.cidx[t];
         ai = cur_ff.aidx[t];
         a  = cur_ff.apal[ai];
         case (cur_ff.mode)
            bcntbd_pkg::MODE_BC1: begin
               rsp_data_in[c] = cur_ff.cpal[ci];
            end
            bcntbd_pkg::MODE_BC3: begin
               rsp_data_in[c] = {a, cur_ff.cpal[ci][23:0]};
            end
            bcntbd_pkg::MODE_BC4: begin
               rsp_data_in[c] = {8'hff, a, a, a};
            end
            default: begin
               rsp_data_in[c] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         row_ff     <= 2'd0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         row_ff     <= row_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= blk_data;
      end
      if (load_row) begin
         rsp_data_ff <= rsp_data_in;
         rsp_row_ff  <= row_ff;
         rsp_last_ff <= row_ff == bcntbd_pkg::ROW_LAST;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_row_ff;
   assign rsp_tlast  = rsp_last_ff;

   row_needs_block: assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd0 |-> cur_vld_ff)
      else $error("Row counter is mid-block without a current block.");

   row_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      cur_vld_ff && !load_row |=> $stable(row_ff))
      else $error("Row counter moved while the result register was stalled.");

   last_row_marked: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid && rsp_tlast && rsp_tuser == bcntbd_pkg::ROW_LAST)
      else $error("Final row of a block was not marked as last.");

endmodule

// ===== rtl/core/bcn_texture_block_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn texture block decoder core
// Decodes BC1, BC3 and BC4 compressed 4x4 blocks into rows of RGBA8 texels.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is one compressed block: req_tdata carries the
// colour block in bits 63:0 and the alpha block in bits 127:64, and req_tuser
// carries the mode (BC1, BC3, BC4; the unused code gives zero texels).
// Each block gives four items on the rsp_ channel, top row first: four texels
// in rsp_tdata, the row number in rsp_tuser and rsp_tlast on the fourth row.
// The front end registers the block with its expanded endpoints and builds
// both palettes; a short queue holds decoded blocks; the back end emits one
// row per cycle from its result register while the receiver takes rows.
// A block passes the front stage register, a queue slot and the back end's
// current-block register before its first row enters the result register.
// Sustained throughput is set by the back end's single row per cycle.
// After reset all stages and the queue are empty. When the receiver stalls
// the result register holds its row, the back end stops, and the queue and
// front stage fill before req_tready falls.
// ----------------------------------------------------------------------------
module bcn_texture_block_decoder_core #(
   parameter int QUEUE_DEPTH = bcntbd_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // color_block, alpha_block
   input  logic [1:0]    req_tuser,   // op
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // texel_0, texel_1, texel_2, texel_3
   output logic [1:0]    rsp_tuser,   // row_index
   output logic          rsp_tlast    // last_row
);

   logic                front_vld;
   logic                front_rdy;
   bcntbd_pkg::blk_type front_data;
   logic                back_vld;
   logic                back_rdy;
   bcntbd_pkg::blk_type back_data;

   bcntbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .blk_vld    (front_vld),
      .blk_rdy    (front_rdy),
      .blk_data   (front_data)
   );

   bcntbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (front_vld),
      .in_rdy   (front_rdy),
      .in_data  (front_data),
      .out_vld  (back_vld),
      .out_rdy  (back_rdy),
      .out_data (back_data)
   );

   bcntbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .blk_vld    (back_vld),
      .blk_rdy    (back_rdy),
      .blk_data   (back_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn texture block decoder testbench
// Sends BC1, BC3, BC4 and unused-mode blocks through the decoder core, first
// from a table of directed blocks and then at random. Each accepted block is
// decoded by an independent palette model into four expected rows, which are
// compared field by field with the rows that come back. Outside a steady
// stretch both sides idle at random; the receiver once lets the core fill.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BLOCKS = 90;
   localparam int STEADY_FIRST  = 30;
   localparam int STEADY_LAST   = 70;
   localparam int HOLD_AT       = 35;
   localparam int HOLD_CYCLES   = 50;
   localparam int STALL_LIMIT   = 500;
   localparam int TAIL_CYCLES   = 8;

   typedef struct packed {
      bcntbd_pkg::mode_type mode;
      logic [63:0]          cblk;
      logic [63:0]          ablk;
      logic                 known;
      logic [31:0]          texel;
   } blk_item_type;

   typedef struct packed {
      logic [1:0]       row;
      logic [3:0][31:0] texels;
      logic             last;
   } row_expect_type;

   // Colour block is {indices, c1, c0}; alpha block is {indices, a1, a0}.
   // Where known is set, every texel of the block has the value given.
   localparam blk_item_type DIRECTED_BLOCKS [0:20] = '{
      '{bcntbd_pkg::MODE_BC1,  64'h00000000_0000_FFFF, 64'h000000000000_0000, 1'b1,
        32'hFFFFFFFF},
      '{bcntbd_pkg::MODE_BC1,  64'h55555555_0000_FFFF, 64'h000000000000_0000, 1'b1,
        32'hFF000000},
      '{bcntbd_pkg::MODE_BC1,  64'hFFFFFFFF_0000_0000, 64'h000000000000_0000, 1'b1,
        32'h00000000},
      '{bcntbd_pkg::MODE_BC1,  64'hE4E4E4E4_0000_FFFF, 64'h000000000000_0000, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC1,  64'hE4E4E4E4_FFFF_0000, 64'h000000000000_0000, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC1,  64'h1B1B1B1B_1234_1234, 64'h000000000000_0000, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC1,  64'h39C6A55A_0000_0001, 64'h000000000000_0000, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC1,  64'h00000000_0000_FFFF, 64'hFFFFFFFFFFFF_FFFF, 1'b1,
        32'hFFFFFFFF},
      '{bcntbd_pkg::MODE_BC3,  64'h00000000_0000_FFFF, 64'h000000000000_00FF, 1'b1,
        32'hFFFFFFFF},
      '{bcntbd_pkg::MODE_BC3,  64'h55555555_0000_FFFF, 64'hFFFFFFFFFFFF_0000, 1'b1,
        32'hFF000000},
      '{bcntbd_pkg::MODE_BC3,  64'hE4E4E4E4_F81F_07E0, 64'hFAC688FAC688_00FF, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC3,  64'h1B1B1B1B_F81F_07E0, 64'hFAC688FAC688_F010, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC3,  64'hA5A5A5A5_8410_7BEF, 64'hFAC688FAC688_7F80, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC4,  64'h00000000_0000_0000, 64'h000000000000_0000, 1'b1,
        32'hFF000000},
      '{bcntbd_pkg::MODE_BC4,  64'hFFFFFFFF_FFFF_FFFF, 64'h000000000000_00FF, 1'b1,
        32'hFFFFFFFF},
      '{bcntbd_pkg::MODE_BC4,  64'h00000000_0000_0000, 64'hFAC688FAC688_00FF, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC4,  64'h00000000_0000_0000, 64'hFAC688FAC688_F010, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_BC4,  64'h00000000_0000_0000, 64'hFAC688FAC688_3333, 1'b0,
        32'h0},
      '{bcntbd_pkg::MODE_NONE, 64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFFFFFF_FFFF, 1'b1,
        32'h00000000},
      '{bcntbd_pkg::MODE_NONE, 64'h00000000_0000_0000, 64'h000000000000_0000, 1'b1,
        32'h00000000},
      '{bcntbd_pkg::MODE_BC3,  64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFFFFFF_FFFF, 1'b1,
        32'hFF000000}
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // color_block, alpha_block
   logic [1:0]   req_tuser = bcntbd_pkg::MODE_BC1;   // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;   // texel_0, texel_1, texel_2, texel_3
   logic [1:0]   rsp_tuser;   // row_index
   logic         rsp_tlast;   // last_row

   row_expect_type rows_due [$];
   blk_item_type   blocks [$];
   int             errors = 0;
   int             taken = 0;
   bit             steady = 1'b0;

   bcn_texture_block_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void decode_rows(input blk_item_type b);
      int unsigned    ep [2][3];
      int unsigned    cpal [4][4];
      int unsigned    apal [8];
      int unsigned    word, a0, a1, ci, ai, t;
      logic           c_gt;
      row_expect_type r;
      for (int j = 0; j < 2; j++) begin
         word = b.cblk[16*j +: 16];
         ep[j][0] = ((word >> 11) & 31) * 255 / 31;
         ep[j][1] = ((word >> 5) & 63) * 255 / 63;
         ep[j][2] = (word & 31) * 255 / 31;
      end
      c_gt = b.cblk[15:0] > b.cblk[31:16];
      for (int k = 0; k < 3; k++) begin
         cpal[0][k] = ep[0][k];
         cpal[1][k] = ep[1][k];
         cpal[2][k] = c_gt ? (2 * ep[0][k] + ep[1][k]) / 3 : (ep[0][k] + ep[1][k]) / 2;
         cpal[3][k] = c_gt ? (ep[0][k] + 2 * ep[1][k]) / 3 : 0;
      end
      cpal[0][3] = 255;
      cpal[1][3] = 255;
      cpal[2][3] = 255;
      cpal[3][3] = c_gt ? 255 : 0;
      a0 = b.ablk[7:0];
      a1 = b.ablk[15:8];
      apal[0] = a0;
      apal[1] = a1;
      for (int i = 1; i <= 6; i++) begin
         if (a0 > a1) begin
            apal[1 + i] = ((7 - i) * a0 + i * a1) / 7;
         end else if (i <= 4) begin
            apal[1 + i] = ((5 - i) * a0 + i * a1) / 5;
         end
      end
      if (a0 <= a1) begin
         apal[6] = 0;
         apal[7] = 255;
      end
      for (int row = 0; row < 4; row++) begin
         r.row = 2'(row);
         r.last = (2'(row) == bcntbd_pkg::ROW_LAST);
         for (int col = 0; col < 4; col++) begin
            t = row * 4 + col;
            ci = b.cblk[32 + 2 * t +: 2];
            ai = b.ablk[16 + 3 * t +: 3];
            if (b.known) begin
               r.texels[col] = b.texel;
            end else begin
               case (b.mode)
                  bcntbd_pkg::MODE_BC1: r.texels[col] = {8'(cpal[ci][3]), 8'(cpal[ci][2]),
                                                         8'(cpal[ci][1]), 8'(cpal[ci][0])};
                  bcntbd_pkg::MODE_BC3: r.texels[col] = {8'(apal[ai]), 8'(cpal[ci][2]),
                                                         8'(cpal[ci][1]), 8'(cpal[ci][0])};
                  bcntbd_pkg::MODE_BC4: r.texels[col] = {8'hFF, 8'(apal[ai]), 8'(apal[ai]),
                                                         8'(apal[ai])};
                  default:              r.texels[col] = 32'h0;
               endcase
            end
         end
         rows_due = {rows_due, r};
      end
   endfunction

   function automatic blk_item_type random_block();
      blk_item_type b;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         b.mode = bcntbd_pkg::MODE_BC1;
      end else if (pick < 75) begin
         b.mode = bcntbd_pkg::MODE_BC3;
      end else if (pick < 96) begin
         b.mode = bcntbd_pkg::MODE_BC4;
      end else begin
         b.mode = bcntbd_pkg::MODE_NONE;
      end
      b.cblk = {$urandom, $urandom};
      b.ablk = {$urandom, $urandom};
      if ($urandom_range(99) < 20) begin
         b.cblk[31:16] = b.cblk[15:0];
      end
      if ($urandom_range(99) < 20) begin
         b.ablk[15:8] = b.ablk[7:0];
      end
      b.known = 1'b0;
      b.texel = 32'h0;
      return b;
   endfunction

   always @(posedge clock) begin : check_rows
      row_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rows_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected row, expected none, got row %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = rows_due.pop_front();
            if (rsp_tuser !== want.row) begin
               errors++;
               $display("%0t: row_index expected %0d, got %0d", $time, want.row, rsp_tuser);
            end
            for (int c = 0; c < 4; c++) begin
               if (rsp_tdata[32*c +: 32] !== want.texels[c]) begin
                  errors++;
                  $display("%0t: row %0d texel_%0d expected %h, got %h", $time, want.row,
                           c, want.texels[c], rsp_tdata[32*c +: 32]);
               end
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: row %0d last_row expected %b, got %b", $time, want.row,
                        want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin : stall_watch
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin : receiver
      int  hold_left;
      bit  held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && taken >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 18);
         end
      end
   end

   initial begin : sender
      blk_item_type b;
      bit           offered;
      foreach (DIRECTED_BLOCKS[i]) begin
         blocks = {blocks, DIRECTED_BLOCKS[i]};
      end
      repeat (RANDOM_BLOCKS) begin
         blocks = {blocks, random_block()};
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      offered = 1'b0;
      while (taken < blocks.size()) begin
         @(negedge clock);
         steady = (taken >= STEADY_FIRST) && (taken < STEADY_LAST);
         if (!offered) begin
            if (!steady && $urandom_range(99) < 18) begin
               req_tvalid <= 1'b0;
            end else begin
               b = blocks[taken];
               req_tdata <= {b.ablk, b.cblk};
               req_tuser <= b.mode;
               req_tvalid <= 1'b1;
               offered = 1'b1;
            end
         end
         @(posedge clock);
         if (offered && req_tready) begin
            decode_rows(b);
            offered = 1'b0;
            taken++;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      steady = 1'b0;
      while (rows_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bcntbd_pkg.sv
rtl/core/bcntbd_front.sv
rtl/core/bcntbd_queue.sv
rtl/core/bcntbd_back.sv
rtl/core/bcn_texture_block_decoder_core.sv
dv/tb.sv
